### design/llc_pkg.sv
// ----------------------------------------------------------------------------
// llc_pkg - shared types and constants of the lead-lag compensator
// Holds the coefficient register map, the reset values and the control word
// that the sequencer passes to the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package llc_pkg;

   localparam int COEF_WIDTH     = 32;
   localparam int NUM_REGS       = 6;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic [2:0] {
      REG_LEAD_B0 = 3'd0,
      REG_LEAD_B1 = 3'd1,
      REG_LEAD_A1 = 3'd2,
      REG_LAG_B0  = 3'd3,
      REG_LAG_B1  = 3'd4,
      REG_LAG_A1  = 3'd5
   } reg_index_type;

   // 1.0 in Q16.16
   localparam logic [COEF_WIDTH-1:0] COEF_RESET_B0    = 32'h0001_0000;
   localparam logic [COEF_WIDTH-1:0] COEF_RESET_OTHER = 32'h0000_0000;

   typedef logic [NUM_REGS-1:0][COEF_WIDTH-1:0] coef_array_type;

   typedef struct packed {
      logic issue;   // a product is started this cycle
      logic first;   // product opens a new sum
      logic negate;  // product is subtracted
   } mac_ctl_type;

endpackage

### design/lead_lag_iir_compensator_unit.sv
// ----------------------------------------------------------------------------
// lead_lag_iir_compensator_unit - lead section then lag section, first order
// Each section forms b0*x + b1*x_prev - a1*y_prev on one shared multiplier,
// rounds to nearest, shifts by the fraction bits and saturates.
//
//   channel  dir   handshake              payload
//   req      in    req_tvalid/tready      error_sample
//   rsp      out   rsp_tvalid/tready      drive_sample
//   csr      in    psel/penable/pready    six Q16.16 coefficients
//
// per section, three products pass through the one multiplier, a drain step
// empties the product and accumulator registers and a latch step stores the
// section output. a new sample is taken only in the idle state, after the
// previous one has left the lag section.
// reset loads the coefficient defaults and clears the section history.
// a finished sample waits in the output register; the next sample is taken
// meanwhile and holds in its last step until that register frees.
// ----------------------------------------------------------------------------
module lead_lag_iir_compensator_unit #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // [SAMPLE_WIDTH-1:0] error_sample, zero padded to whole bytes
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [SAMPLE_WIDTH-1:0] drive_sample, zero padded to whole bytes
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [llc_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [llc_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [llc_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                  csr_pready
);
   import llc_pkg::*;

   localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_LATCH
   } state_type;

   typedef enum logic [1:0] {
      STEP_B0,
      STEP_B1,
      STEP_A1
   } step_type;

   state_type                state_ff, state_in;
   step_type                 step_ff, step_in;
   logic                     lag_sec_ff, lag_sec_in;
   logic [SAMPLE_WIDTH-1:0]  cur_x_ff, cur_x_in;
   logic [SAMPLE_WIDTH-1:0]  lead_prev_in_ff, lead_prev_in_in;
   logic [SAMPLE_WIDTH-1:0]  lead_prev_out_ff, lead_prev_out_in;
   logic [SAMPLE_WIDTH-1:0]  lag_prev_in_ff, lag_prev_in_in;
   logic [SAMPLE_WIDTH-1:0]  lag_prev_out_ff, lag_prev_out_in;
   logic [SAMPLE_WIDTH-1:0]  rsp_data_ff, rsp_data_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   coef_array_type           coef;
   mac_ctl_type              mac_ctl;
   logic [COEF_WIDTH-1:0]    coef_op;
   logic [SAMPLE_WIDTH-1:0]  sample_op;
   logic [SAMPLE_WIDTH-1:0]  mac_result;

   llc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   llc_mac #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mac_ctl),
      .coef_op   (coef_op),
      .sample_op (sample_op),
      .result    (mac_result)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_data_ff);

   // operand select for the current product
   always_comb begin
      mac_ctl.issue  = (state_ff == ST_ISSUE);
      mac_ctl.first  = (step_ff == STEP_B0);
      mac_ctl.negate = (step_ff == STEP_A1);
      case (step_ff)
         STEP_B0: begin
            coef_op   = lag_sec_ff ? coef[REG_LAG_B0] : coef[REG_LEAD_B0];
            sample_op = cur_x_ff;
         end
         STEP_B1: begin
            coef_op   = lag_sec_ff ? coef[REG_LAG_B1] : coef[REG_LEAD_B1];
            sample_op = lag_sec_ff ? lag_prev_in_ff : lead_prev_in_ff;
         end
         STEP_A1: begin
            coef_op   = lag_sec_ff ? coef[REG_LAG_A1] : coef[REG_LEAD_A1];
            sample_op = lag_sec_ff ? lag_prev_out_ff : lead_prev_out_ff;
         end
         default: begin
            coef_op   = '0;
            sample_op = '0;
         end
      endcase
   end

   always_comb begin
      state_in         = state_ff;
      step_in          = step_ff;
      lag_sec_in       = lag_sec_ff;
      cur_x_in         = cur_x_ff;
      lead_prev_in_in  = lead_prev_in_ff;
      lead_prev_out_in = lead_prev_out_ff;
      lag_prev_in_in   = lag_prev_in_ff;
      lag_prev_out_in  = lag_prev_out_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cur_x_in   = req_tdata[SAMPLE_WIDTH-1:0];
               lag_sec_in = 1'b0;
               step_in    = STEP_B0;
               state_in   = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            case (step_ff)
               STEP_B0: step_in = STEP_B1;
               STEP_B1: step_in = STEP_A1;
               default: begin
                  step_in  = STEP_B0;
                  state_in = ST_DRAIN;
               end
            endcase
         end
         ST_DRAIN: begin
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            if (!lag_sec_ff) begin
               lead_prev_in_in  = cur_x_ff;
               lead_prev_out_in = mac_result;
               cur_x_in         = mac_result;
               lag_sec_in       = 1'b1;
               step_in          = STEP_B0;
               state_in         = ST_ISSUE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               lag_prev_in_in  = cur_x_ff;
               lag_prev_out_in = mac_result;
               rsp_data_in     = mac_result;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff         <= ST_IDLE;
         step_ff          <= STEP_B0;
         lag_sec_ff       <= 1'b0;
         lead_prev_in_ff  <= '0;
         lead_prev_out_ff <= '0;
         lag_prev_in_ff   <= '0;
         lag_prev_out_ff  <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         step_ff          <= step_in;
         lag_sec_ff       <= lag_sec_in;
         lead_prev_in_ff  <= lead_prev_in_in;
         lead_prev_out_ff <= lead_prev_out_in;
         lag_prev_in_ff   <= lag_prev_in_in;
         lag_prev_out_ff  <= lag_prev_out_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

endmodule

### design/llc_csr.sv
// ----------------------------------------------------------------------------
// llc_csr - coefficient register bank
// Six signed Q16.16 coefficients behind a simple APB-style port.
// ----------------------------------------------------------------------------
module llc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [llc_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [llc_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [llc_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output llc_pkg::coef_array_type              coef
);
   import llc_pkg::*;

   coef_array_type coef_ff;
   coef_array_type coef_in;
   logic [2:0]     reg_idx;
   logic           wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign coef       = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (wr_en && (reg_idx < 3'(NUM_REGS))) begin
         coef_in[reg_idx] = csr_pwdata;
      end
   end

   always_comb begin
      if (reg_idx < 3'(NUM_REGS)) begin
         csr_prdata = coef_ff[reg_idx];
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[REG_LEAD_B0] <= COEF_RESET_B0;
         coef_ff[REG_LEAD_B1] <= COEF_RESET_OTHER;
         coef_ff[REG_LEAD_A1] <= COEF_RESET_OTHER;
         coef_ff[REG_LAG_B0]  <= COEF_RESET_B0;
         coef_ff[REG_LAG_B1]  <= COEF_RESET_OTHER;
         coef_ff[REG_LAG_A1]  <= COEF_RESET_OTHER;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

### design/llc_mac.sv
// ----------------------------------------------------------------------------
// llc_mac - shared multiply-accumulate unit
// One signed coefficient-by-sample multiplier with a registered product,
// followed by a full-width accumulator preloaded with the rounding constant.
// The accumulator output is shifted, and saturated to the sample width.
// ----------------------------------------------------------------------------
module llc_mac #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  llc_pkg::mac_ctl_type                ctl,
   input  logic [llc_pkg::COEF_WIDTH-1:0]      coef_op,
   input  logic [SAMPLE_WIDTH-1:0]             sample_op,
   output logic [SAMPLE_WIDTH-1:0]             result
);
   import llc_pkg::*;

   localparam int PROD_W = COEF_WIDTH + SAMPLE_WIDTH;
   localparam int ACC_W  = PROD_W + 2;
   localparam int HI_W   = ACC_W - SAMPLE_WIDTH + 1;
   localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   mac_ctl_type              op_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  acc_base;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  shifted;
   logic [HI_W-1:0]          hi_bits;

   assign prod_in  = $signed(coef_op) * $signed(sample_op);
   assign prod_ext = ACC_W'(prod_ff);
   assign acc_base = op_ff.first ? ROUND : acc_ff;

   always_comb begin
      acc_in = acc_ff;
      if (op_ff.issue) begin
         if (op_ff.negate) begin
            acc_in = acc_base - prod_ext;
         end else begin
            acc_in = acc_base + prod_ext;
         end
      end
   end

   // floor shift, then clamp when the upper bits are not a pure sign extension
   assign shifted = acc_ff >>> COEF_FRAC_BITS;
   assign hi_bits = shifted[ACC_W-1:SAMPLE_WIDTH-1];

   always_comb begin
      if ((hi_bits == '0) || (hi_bits == '1)) begin
         result = shifted[SAMPLE_WIDTH-1:0];
      end else if (shifted[ACC_W-1]) begin
         result = SAT_MIN;
      end else begin
         result = SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (reset) begin
         op_ff <= '0;
      end else begin
         op_ff <= ctl;
      end
   end

endmodule
